FILE: src/view_matrix_axis_rotate_unit_assert.svh
// ----------------------------------------------------------------------------
// View matrix axis rotate unit: assertion macros
// Shared property templates clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIEW_MATRIX_AXIS_ROTATE_UNIT_ASSERT_SVH
`define VIEW_MATRIX_AXIS_ROTATE_UNIT_ASSERT_SVH

// same-cycle implication
`define VMAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VMAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vmar_pkg.sv
// ----------------------------------------------------------------------------
// vmar_pkg
// Types, constants and address helpers for the view matrix axis rotate unit.
// ----------------------------------------------------------------------------
package vmar_pkg;

    // angle units: 1/64 degree
    localparam int HALF_TURN_DEG  = 180;
    localparam int UNITS_PER_DEG  = 64;
    localparam int HALF_TURN      = HALF_TURN_DEG * UNITS_PER_DEG;
    localparam int FULL_TURN      = 2 * HALF_TURN;
    localparam int QUARTER_TURN   = HALF_TURN / 2;

    localparam int ATAN_COUNT     = 30;
    localparam logic signed [33:0] TRIG_ONE  = 34'sd1073741824;
    localparam logic signed [33:0] GAIN_INV  = 34'sd652032874;

    // atan(2^-i) in units of 2^-24 degree
    localparam logic signed [32:0] ATAN_TABLE [ATAN_COUNT] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938, 33'sd60000934,
        33'sd30029717,  33'sd15018523,  33'sd7509720,   33'sd3754917,   33'sd1877466,
        33'sd938734,    33'sd469367,    33'sd234684,    33'sd117342,    33'sd58671,
        33'sd29335,     33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
        33'sd917,       33'sd458,       33'sd229,       33'sd115,       33'sd57,
        33'sd29,        33'sd14,        33'sd7,         33'sd4,         33'sd2
    };

    // entry store: 9 rotation entries row-major, then 3 offsets
    localparam int ENTRY_COUNT = 12;
    localparam int ADDR_W      = 4;
    localparam logic [ADDR_W-1:0] ROW_LEN     = 4'd3;
    localparam logic [ADDR_W-1:0] OFFSET_BASE = 4'd9;
    localparam logic [ADDR_W-1:0] DIAG_XX     = 4'd0;
    localparam logic [ADDR_W-1:0] DIAG_YY     = 4'd4;
    localparam logic [ADDR_W-1:0] DIAG_ZZ     = 4'd8;
    localparam logic [1:0]        OFFSET_SLOT = 2'd3;

    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_PAIR_RD,
        S_PAIR_MUL,
        S_PAIR_WR,
        S_ROW_RD,
        S_ROW_PUT
    } t_state;

    // partial products of one pair: p' = p*c + q*s, q' = q*c - p*s
    typedef enum logic [2:0] {
        T_AH_C  = 3'd0,
        T_BH_S  = 3'd1,
        T_AL_C  = 3'd2,
        T_BL_S  = 3'd3,
        T_BH_C  = 3'd4,
        T_AH_NS = 3'd5,
        T_BL_C  = 3'd6,
        T_AL_NS = 3'd7
    } t_term;

    typedef struct packed {
        logic  go;
        t_term term;
    } t_mac_ctl;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } t_mem_req;

    function automatic logic [1:0] pair_p(input t_axis axis);
        logic [1:0] row;
        case (axis)
            AXIS_X:  row = ROW_Y;
            AXIS_Y:  row = ROW_X;
            AXIS_Z:  row = ROW_Y;
            default: row = ROW_X;
        endcase
        return row;
    endfunction

    function automatic logic [1:0] pair_q(input t_axis axis);
        logic [1:0] row;
        case (axis)
            AXIS_X:  row = ROW_Z;
            AXIS_Y:  row = ROW_Z;
            AXIS_Z:  row = ROW_X;
            default: row = ROW_X;
        endcase
        return row;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] row,
                                                     input logic [1:0] slot);
        logic [ADDR_W-1:0] base;
        base = {2'b00, row};
        if (slot == OFFSET_SLOT) begin
            return OFFSET_BASE + base;
        end
        return ADDR_W'(base * ROW_LEN) + {2'b00, slot};
    endfunction

endpackage

FILE: src/vmar_mem.sv
// ----------------------------------------------------------------------------
// vmar_mem
// Entry store: one write and one registered read port; per-entry valid bits
// return the identity / zero reset contents until an entry is written.
// ----------------------------------------------------------------------------
module vmar_mem #(
    parameter int ENTRY_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vmar_pkg::t_mem_req            i_req,
    input  logic signed [ENTRY_BITS-1:0]  i_wr_data,
    output logic signed [ENTRY_BITS-1:0]  o_rd_data
);
    import vmar_pkg::*;

    localparam logic signed [ENTRY_BITS-1:0] ENTRY_ONE =
        {2'b01, {(ENTRY_BITS-2){1'b0}}};

    logic signed [ENTRY_BITS-1:0] r_mem [ENTRY_COUNT];
    logic        [ENTRY_COUNT-1:0] r_valid;
    logic signed [ENTRY_BITS-1:0] r_rd_data;
    logic signed [ENTRY_BITS-1:0] r_rd_init;
    logic                          r_rd_valid;
    logic signed [ENTRY_BITS-1:0] n_rd_init;

    always_comb begin
        n_rd_init = (i_req.rd_addr inside {DIAG_XX, DIAG_YY, DIAG_ZZ}) ? ENTRY_ONE : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_init <= n_rd_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : r_rd_init;

endmodule

FILE: src/vmar_cordic.sv
// ----------------------------------------------------------------------------
// vmar_cordic
// Angle reduction plus iterative CORDIC, one micro-rotation per cycle.
// Exact results at multiples of 90 degrees; Q2.30 cos and sin out.
// ----------------------------------------------------------------------------
module vmar_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import vmar_pkg::*;

    localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);
    localparam logic signed [16:0] P_HALF    = 17'(HALF_TURN);
    localparam logic signed [16:0] P_FULL    = 17'(FULL_TURN);
    localparam logic signed [16:0] P_QUARTER = 17'(QUARTER_TURN);

    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic        [4:0]  r_iter;
    logic               r_run, r_fin, r_neg, r_done;
    logic signed [31:0] r_cos, r_sin;

    logic signed [16:0] n_wrap, n_fold;
    logic               n_neg;
    logic signed [33:0] x_sh, y_sh, x_cl, y_cl;
    logic signed [32:0] atan_i;

    // reduce to [-180, 180), then fold into [-90, 90]
    always_comb begin
        n_wrap = 17'(i_angle);
        if (n_wrap >= P_HALF) begin
            n_wrap = n_wrap - P_FULL;
        end else if (n_wrap < -P_HALF) begin
            n_wrap = n_wrap + P_FULL;
        end
        n_fold = n_wrap;
        n_neg  = 1'b0;
        if (n_wrap > P_QUARTER) begin
            n_fold = n_wrap - P_HALF;
            n_neg  = 1'b1;
        end else if (n_wrap < -P_QUARTER) begin
            n_fold = n_wrap + P_HALF;
            n_neg  = 1'b1;
        end
    end

    always_comb begin
        x_sh   = r_x >>> r_iter;
        y_sh   = r_y >>> r_iter;
        atan_i = ATAN_TABLE[r_iter];
        x_cl   = (r_x > TRIG_ONE) ? TRIG_ONE : ((r_x < -TRIG_ONE) ? -TRIG_ONE : r_x);
        y_cl   = (r_y > TRIG_ONE) ? TRIG_ONE : ((r_y < -TRIG_ONE) ? -TRIG_ONE : r_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= n_neg;
            r_iter <= '0;
            r_z    <= 33'(n_fold) <<< 18;
            if (n_fold == 17'sd0) begin
                r_x <= TRIG_ONE;
                r_y <= '0;
            end else if (n_fold == P_QUARTER) begin
                r_x <= '0;
                r_y <= TRIG_ONE;
            end else if (n_fold == -P_QUARTER) begin
                r_x <= '0;
                r_y <= -TRIG_ONE;
            end else begin
                r_x <= GAIN_INV;
                r_y <= '0;
            end
        end else if (r_run) begin
            r_iter <= r_iter + 5'd1;
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_i;
            end
        end
        if (r_fin) begin
            r_cos <= 32'(r_neg ? -x_cl : x_cl);
            r_sin <= 32'(r_neg ? -y_cl : y_cl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            if (i_start) begin
                r_run <= !(n_fold == 17'sd0 || n_fold == P_QUARTER || n_fold == -P_QUARTER);
                r_fin <= n_fold == 17'sd0 || n_fold == P_QUARTER || n_fold == -P_QUARTER;
            end else begin
                r_fin <= r_run && (r_iter == LAST_ITER);
                if (r_run && (r_iter == LAST_ITER)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

FILE: src/vmar_mac.sv
// ----------------------------------------------------------------------------
// vmar_mac
// Split-operand multiply-accumulate for one mixed entry, sat(round(x / 2^30))
// with x = a*c + b*s or b*c - a*s; four partial products per entry.
// ----------------------------------------------------------------------------
module vmar_mac #(
    parameter int ENTRY_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vmar_pkg::t_mac_ctl            i_ctl,
    input  logic signed [ENTRY_BITS-1:0]  i_a,
    input  logic signed [ENTRY_BITS-1:0]  i_b,
    input  logic signed [31:0]            i_cos,
    input  logic signed [31:0]            i_sin,
    output logic signed [ENTRY_BITS-1:0]  o_result
);
    import vmar_pkg::*;

    localparam int AW = ENTRY_BITS + 36;
    localparam logic signed [AW-1:0] E_MAX = {{(AW-ENTRY_BITS+1){1'b0}}, {(ENTRY_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] E_MIN = ~E_MAX;
    localparam logic signed [AW-1:0] HALF  = {{(AW-30){1'b0}}, 1'b1, 29'd0};

    logic signed [32:0] a_hi, b_hi, a_lo, b_lo, c_ext, s_ext, ns_ext;
    logic signed [32:0] op_x, op_y;
    logic               sel_hi, sel_clear;
    logic signed [65:0] r_prod;
    logic               r_go, r_hi, r_clear;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] term_ext, rnd, quo;

    always_comb begin
        a_hi   = 33'(i_a >>> 16);
        b_hi   = 33'(i_b >>> 16);
        a_lo   = {17'd0, i_a[15:0]};
        b_lo   = {17'd0, i_b[15:0]};
        c_ext  = 33'(i_cos);
        s_ext  = 33'(i_sin);
        ns_ext = -s_ext;
        sel_hi    = 1'b0;
        sel_clear = 1'b0;
        case (i_ctl.term)
            T_AH_C:  begin op_x = a_hi; op_y = c_ext;  sel_hi = 1'b1; sel_clear = 1'b1; end
            T_BH_S:  begin op_x = b_hi; op_y = s_ext;  sel_hi = 1'b1; end
            T_AL_C:  begin op_x = a_lo; op_y = c_ext;  end
            T_BL_S:  begin op_x = b_lo; op_y = s_ext;  end
            T_BH_C:  begin op_x = b_hi; op_y = c_ext;  sel_hi = 1'b1; sel_clear = 1'b1; end
            T_AH_NS: begin op_x = a_hi; op_y = ns_ext; sel_hi = 1'b1; end
            T_BL_C:  begin op_x = b_lo; op_y = c_ext;  end
            T_AL_NS: begin op_x = a_lo; op_y = ns_ext; end
            default: begin op_x = '0;   op_y = '0;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= op_x * op_y;
        r_hi    <= sel_hi;
        r_clear <= sel_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_ctl.go;
        end
    end

    always_comb begin
        term_ext = r_hi ? (AW'(r_prod) <<< 16) : AW'(r_prod);
        rnd      = r_acc + HALF;
        quo      = rnd >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (r_go) begin
            r_acc <= r_clear ? term_ext : r_acc + term_ext;
        end
    end

    always_comb begin
        if (quo > E_MAX) begin
            o_result = ENTRY_BITS'(E_MAX);
        end else if (quo < E_MIN) begin
            o_result = ENTRY_BITS'(E_MIN);
        end else begin
            o_result = ENTRY_BITS'(quo);
        end
    end

endmodule

FILE: src/view_matrix_axis_rotate_unit.sv
// ----------------------------------------------------------------------------
// view_matrix_axis_rotate_unit
// Incremental axis rotation of a 3x4 view transform held in an entry store.
// ----------------------------------------------------------------------------
// Each input transfer names an axis and an angle in 1/64 degree; the unit
// takes cos/sin by CORDIC, mixes the two rows of that axis (offsets too) in
// place, then sends rows x, y, z with tlast on row z. Transforms start as
// identity with zero offsets. One item is handled at a time. The time a
// rotation takes is set by the CORDIC iterations, skipped for multiples of
// 90 degrees, and by the single shared multiplier (four partial products
// per mixed entry, eight entries) behind the entry store; axis code 3 (no
// update) skips both. The next transfer is taken while the z row still
// waits at the output.
module view_matrix_axis_rotate_unit #(
    parameter int ENTRY_BITS   = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [15:0] angle
    input  logic [1:0]   s_axis_tuser,   // [1:0] operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [31:0] col_x, [63:32] col_y, [95:64] col_z, [127:96] offset
    output logic [1:0]   m_axis_tuser,   // [1:0] row
    output logic         m_axis_tlast
);
    import vmar_pkg::*;

    t_state r_state, n_state;
    logic [3:0] r_cnt;
    logic [1:0] r_k, r_row;
    t_axis      r_axis;

    logic signed [ENTRY_BITS-1:0] r_a, r_b, r_np, r_nq;
    logic signed [ENTRY_BITS-1:0] r_fld [4];
    logic signed [ENTRY_BITS-1:0] r_out_x, r_out_y, r_out_z, r_out_off;
    logic [1:0]  r_out_row;
    logic        r_out_valid;

    t_mem_req   mem_req;
    t_mac_ctl   mac_ctl;
    logic signed [ENTRY_BITS-1:0] rd_data, wr_data, mac_res;
    logic        cordic_start, cordic_done;
    logic signed [31:0] cos_v, sin_v;
    logic        cap_a, cap_b, cap_np, cap_nq, cap_fld, out_load, out_free;
    logic [ADDR_W-1:0] addr_p, addr_q;
    t_axis       in_axis;

    assign in_axis  = t_axis'(s_axis_tuser);
    assign addr_p   = entry_addr(pair_p(r_axis), r_k);
    assign addr_q   = entry_addr(pair_q(r_axis), r_k);
    assign out_free = !r_out_valid || m_axis_tready;

    vmar_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (signed'(s_axis_tdata)),
        .o_done  (cordic_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    vmar_mem #(.ENTRY_BITS(ENTRY_BITS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    vmar_mac #(.ENTRY_BITS(ENTRY_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_cos    (cos_v),
        .i_sin    (sin_v),
        .o_result (mac_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (in_axis == AXIS_NONE) ? S_ROW_RD : S_TRIG;
                end
            end
            S_TRIG: begin
                if (cordic_done) begin
                    n_state = S_PAIR_RD;
                end
            end
            S_PAIR_RD: begin
                if (r_cnt == 4'd2) begin
                    n_state = S_PAIR_MUL;
                end
            end
            S_PAIR_MUL: begin
                if (r_cnt == 4'd9) begin
                    n_state = S_PAIR_WR;
                end
            end
            S_PAIR_WR: begin
                if (r_cnt == 4'd1) begin
                    n_state = (r_k == OFFSET_SLOT) ? S_ROW_RD : S_PAIR_RD;
                end
            end
            S_ROW_RD: begin
                if (r_cnt == 4'd4) begin
                    n_state = S_ROW_PUT;
                end
            end
            S_ROW_PUT: begin
                if (out_free) begin
                    n_state = (r_row == ROW_Z) ? S_IDLE : S_ROW_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = 1'b0;
        cordic_start    = 1'b0;
        mem_req         = '0;
        mac_ctl.go      = 1'b0;
        mac_ctl.term    = t_term'(r_cnt[2:0]);
        wr_data         = r_np;
        cap_a           = 1'b0;
        cap_b           = 1'b0;
        cap_np          = 1'b0;
        cap_nq          = 1'b0;
        cap_fld         = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                cordic_start  = s_axis_tvalid && (in_axis != AXIS_NONE);
            end
            S_PAIR_RD: begin
                mem_req.rd_en   = (r_cnt == 4'd0) || (r_cnt == 4'd1);
                mem_req.rd_addr = (r_cnt == 4'd0) ? addr_p : addr_q;
                cap_a           = r_cnt == 4'd1;
                cap_b           = r_cnt == 4'd2;
            end
            S_PAIR_MUL: begin
                mac_ctl.go = !r_cnt[3];
                cap_np     = r_cnt == 4'd5;
                cap_nq     = r_cnt == 4'd9;
            end
            S_PAIR_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = (r_cnt == 4'd0) ? addr_p : addr_q;
                wr_data         = (r_cnt == 4'd0) ? r_np : r_nq;
            end
            S_ROW_RD: begin
                mem_req.rd_en   = !r_cnt[2];
                mem_req.rd_addr = entry_addr(r_row, r_cnt[1:0]);
                cap_fld         = r_cnt != 4'd0;
            end
            S_ROW_PUT: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_row       <= ROW_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 4'd0 : r_cnt + 4'd1;
            if (r_state == S_IDLE) begin
                r_k   <= '0;
                r_row <= ROW_X;
            end else if (r_state == S_PAIR_WR && r_cnt == 4'd1) begin
                r_k <= r_k + 2'd1;
            end else if (out_load) begin
                r_row <= r_row + 2'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_axis <= in_axis;
        end
        if (cap_a) begin
            r_a <= rd_data;
        end
        if (cap_b) begin
            r_b <= rd_data;
        end
        if (cap_np) begin
            r_np <= mac_res;
        end
        if (cap_nq) begin
            r_nq <= mac_res;
        end
        if (cap_fld) begin
            r_fld[2'(r_cnt - 4'd1)] <= rd_data;
        end
        if (out_load) begin
            r_out_row <= r_row;
            r_out_x   <= r_fld[0];
            r_out_y   <= r_fld[1];
            r_out_z   <= r_fld[2];
            r_out_off <= r_fld[3];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {32'(r_out_off), 32'(r_out_z), 32'(r_out_y), 32'(r_out_x)};
    assign m_axis_tuser  = r_out_row;
    assign m_axis_tlast  = r_out_row == ROW_Z;

`include "view_matrix_axis_rotate_unit_assert.svh"

    `VMAR_ASSERT_NOW(a_single_port, mem_req.wr_en, !mem_req.rd_en, "store read and write overlap")
    `VMAR_ASSERT_NOW(a_last_on_z, m_axis_tvalid && m_axis_tlast, m_axis_tuser == ROW_Z, "tlast off z row")
    `VMAR_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, r_state != S_IDLE, "accept did not start work")
    `VMAR_ASSERT_NOW(a_done_in_trig, cordic_done, r_state == S_TRIG, "cordic result outside trig wait")

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: view matrix axis rotate unit testbench
// Drives axis/angle transfers into the unit and checks every emitted row
// against a built-in model of the 3x4 view transform (CORDIC sin/cos, row
// mixing with round-half-up and saturation). A short directed table covers
// quadrant folding, exact multiples of 90 degrees, angle extremes and the
// unused axis code; a random part follows with bursty idling on both sides,
// one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb;
    import vmar_pkg::*;

    localparam int ENTRY_BITS     = 32;
    localparam int CORDIC_STEPS   = 16;
    localparam int RANDOM_ITEMS   = 470;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PRINT_CAP      = 50;

    localparam longint UNIT_ONE     = 64'sd1073741824;
    localparam longint CORDIC_START = 64'sd652032874;
    localparam longint ENTRY_MAX    = 64'sd2147483647;
    localparam longint ENTRY_MIN    = -64'sd2147483648;
    localparam longint QUARTER_U    = 64'sd5760;
    localparam longint HALF_U       = 64'sd11520;
    localparam longint FULL_U       = 64'sd23040;

    // atan(2^-i), units of 2^-24 degree
    localparam longint ATAN_DEG24 [30] = '{
        754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466,
        938734, 469367, 234684, 117342, 58671,
        29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57,
        29, 14, 7, 4, 2
    };

    // ux/uy/uz: +-(col+1) of the single +-1.0 entry of each row, when known
    typedef struct packed {
        t_axis              axis;
        logic signed [15:0] angle;
        logic               known;
        logic signed [2:0]  ux;
        logic signed [2:0]  uy;
        logic signed [2:0]  uz;
    } t_stim_row;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] col_x;
        logic [31:0] col_y;
        logic [31:0] col_z;
        logic [31:0] offset;
        logic        last;
    } t_view_row;

    localparam int DIR_N = 23;
    localparam t_stim_row DIR_TAB [DIR_N] = '{
        '{AXIS_NONE, 16'sh7FFF,   1'b1, 3'sd1,  3'sd2, 3'sd3},
        '{AXIS_Z,    16'sd5760,   1'b1, -3'sd2, 3'sd1, 3'sd3},
        '{AXIS_X,    16'sd0,      1'b1, -3'sd2, 3'sd1, 3'sd3},
        '{AXIS_Y,    16'sd11520,  1'b1, 3'sd2,  3'sd1, -3'sd3},
        '{AXIS_X,    -16'sd5760,  1'b1, 3'sd2,  3'sd3, 3'sd1},
        '{AXIS_Z,    16'sd23040,  1'b1, 3'sd2,  3'sd3, 3'sd1},
        '{AXIS_Y,    -16'sd11520, 1'b1, -3'sd2, 3'sd3, -3'sd1},
        '{AXIS_X,    16'sd17280,  1'b1, -3'sd2, 3'sd1, 3'sd3},
        '{AXIS_NONE, 16'sh8000,   1'b1, -3'sd2, 3'sd1, 3'sd3},
        '{AXIS_Z,    16'sd2880,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_X,    -16'sd2880,  1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Y,    16'sd1920,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Z,    16'sd1,      1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_X,    -16'sd1,     1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Y,    16'sh7FFF,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Z,    16'sh8000,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_X,    16'sd5759,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Y,    16'sd5761,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Z,    16'sd11519,  1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_X,    -16'sd11521, 1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Y,    -16'sd23040, 1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_NONE, 16'sh1234,   1'b0, 3'sd0,  3'sd0, 3'sd0},
        '{AXIS_Z,    16'sd12345,  1'b0, 3'sd0,  3'sd0, 3'sd0}
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;   // [15:0] angle
    logic [1:0]   s_axis_tuser;   // [1:0] operation
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // [31:0] col_x, [63:32] col_y, [95:64] col_z, [127:96] offset
    logic [1:0]   m_axis_tuser;   // [1:0] row
    logic         m_axis_tlast;

    longint    view_rot [9];
    longint    view_ofs [3];
    t_view_row row_q [$];
    int        err_count    = 0;
    int        stall_cycles = 0;
    int        sink_hold    = 0;
    bit        src_pace     = 1'b1;
    bit        sink_pace    = 1'b1;
    bit        calm         = 1'b0;

    view_matrix_axis_rotate_unit #(
        .ENTRY_BITS  (ENTRY_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
    end

    // ---------------- view transform model ----------------
    function automatic longint mix_entry(input longint a, input longint b,
                                         input longint c, input longint s);
        longint acc;
        acc = (a * c + b * s + (longint'(1) << 29)) >>> 30;
        if (acc > ENTRY_MAX) begin
            acc = ENTRY_MAX;
        end else if (acc < ENTRY_MIN) begin
            acc = ENTRY_MIN;
        end
        return acc;
    endfunction

    task automatic angle_trig(input logic signed [15:0] angle,
                              output longint cv, output longint sv);
        longint r, x, y, z, t;
        logic   flip;
        r    = longint'(angle) % FULL_U;
        flip = 1'b0;
        if (r >= HALF_U) r = r - FULL_U;
        if (r < -HALF_U) r = r + FULL_U;
        if (r > QUARTER_U) begin
            r    = r - HALF_U;
            flip = 1'b1;
        end else if (r < -QUARTER_U) begin
            r    = r + HALF_U;
            flip = 1'b1;
        end
        if (r == 0) begin
            x = UNIT_ONE;
            y = 0;
        end else if (r == QUARTER_U) begin
            x = 0;
            y = UNIT_ONE;
        end else if (r == -QUARTER_U) begin
            x = 0;
            y = -UNIT_ONE;
        end else begin
            x = CORDIC_START;
            y = 0;
            z = r <<< 18;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                t = x;
                if (z >= 0) begin
                    x = x - (y >>> i);
                    y = y + (t >>> i);
                    z = z - ATAN_DEG24[i];
                end else begin
                    x = x + (y >>> i);
                    y = y - (t >>> i);
                    z = z + ATAN_DEG24[i];
                end
            end
            if (x > UNIT_ONE) x = UNIT_ONE;
            if (x < -UNIT_ONE) x = -UNIT_ONE;
            if (y > UNIT_ONE) y = UNIT_ONE;
            if (y < -UNIT_ONE) y = -UNIT_ONE;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cv = x;
        sv = y;
    endtask

    task automatic rotate_view(input t_axis axis, input logic signed [15:0] angle);
        longint c, s, po, qo;
        longint np [3];
        longint nq [3];
        int     p, q;
        case (axis)
            AXIS_X: begin
                p = 1;
                q = 2;
            end
            AXIS_Y: begin
                p = 0;
                q = 2;
            end
            AXIS_Z: begin
                p = 1;
                q = 0;
            end
            default: return;
        endcase
        angle_trig(angle, c, s);
        for (int k = 0; k < 3; k++) begin
            np[k] = mix_entry(view_rot[p*3+k], view_rot[q*3+k], c, s);
            nq[k] = mix_entry(view_rot[q*3+k], view_rot[p*3+k], c, -s);
        end
        po = mix_entry(view_ofs[p], view_ofs[q], c, s);
        qo = mix_entry(view_ofs[q], view_ofs[p], c, -s);
        for (int k = 0; k < 3; k++) begin
            view_rot[p*3+k] = np[k];
            view_rot[q*3+k] = nq[k];
        end
        view_ofs[p] = po;
        view_ofs[q] = qo;
    endtask

    function automatic t_view_row unit_row(input int r, input logic signed [2:0] code);
        t_view_row v;
        logic [31:0] one;
        v        = '0;
        v.row    = 2'(r);
        v.last   = (r == 2);
        one      = (code < 0) ? -32'sd1073741824 : 32'sd1073741824;
        case (code < 0 ? -code : code)
            3'sd1:   v.col_x = one;
            3'sd2:   v.col_y = one;
            default: v.col_z = one;
        endcase
        return v;
    endfunction

    task automatic queue_rows(input t_stim_row st);
        t_view_row v;
        rotate_view(st.axis, st.angle);
        if (st.known) begin
            row_q.push_back(unit_row(0, st.ux));
            row_q.push_back(unit_row(1, st.uy));
            row_q.push_back(unit_row(2, st.uz));
        end else begin
            for (int r = 0; r < 3; r++) begin
                v.row    = 2'(r);
                v.col_x  = view_rot[r*3][31:0];
                v.col_y  = view_rot[r*3+1][31:0];
                v.col_z  = view_rot[r*3+2][31:0];
                v.offset = view_ofs[r][31:0];
                v.last   = (r == 2);
                row_q.push_back(v);
            end
        end
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_view_row want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_q.size() == 0) begin
                report_mismatch("unexpected row transfer", 32'(m_axis_tuser), 32'd0);
            end else begin
                want = row_q.pop_front();
                if (m_axis_tuser !== want.row)
                    report_mismatch("row", 32'(m_axis_tuser), 32'(want.row));
                if (m_axis_tdata[31:0] !== want.col_x)
                    report_mismatch("col_x", m_axis_tdata[31:0], want.col_x);
                if (m_axis_tdata[63:32] !== want.col_y)
                    report_mismatch("col_y", m_axis_tdata[63:32], want.col_y);
                if (m_axis_tdata[95:64] !== want.col_z)
                    report_mismatch("col_z", m_axis_tdata[95:64], want.col_z);
                if (m_axis_tdata[127:96] !== want.offset)
                    report_mismatch("offset", m_axis_tdata[127:96], want.offset);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- output side pacing ----------------
    always begin
        @(negedge i_clk);
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            repeat (sink_hold) @(negedge i_clk);
            sink_hold = 0;
            m_axis_tready <= 1'b1;
        end else if (!calm && sink_pace && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- input side ----------------
    task automatic push_item(input t_stim_row st);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= st.angle;
        s_axis_tuser  <= st.axis;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_rows(st);
        @(negedge i_clk);
    endtask

    task automatic src_gap();
        if (!calm && src_pace && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        while (row_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        int a;
        case ($urandom_range(0, 5))
            0, 1:    a = $urandom_range(0, 65535);
            2:       a = ($urandom_range(0, 10) - 5) * 5760 + $urandom_range(0, 2) - 1;
            3:       a = $urandom_range(0, 128) - 64;
            4:       a = $urandom_range(0, 46080) - 23040;
            default: a = $urandom_range(0, 65535);
        endcase
        return 16'(a);
    endfunction

    initial begin
        t_stim_row st;
        int        hold_left;
        hold_left = 0;
        for (int i = 0; i < 3; i++) begin
            view_rot[i*4] = UNIT_ONE;
            view_ofs[i]   = 0;
        end
        view_rot[1] = 0; view_rot[2] = 0; view_rot[3] = 0;
        view_rot[5] = 0; view_rot[6] = 0; view_rot[7] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            push_item(DIR_TAB[i]);
            src_gap();
        end
        drain_pause();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                src_pace  = ($urandom_range(0, 3) != 0);
                sink_pace = ($urandom_range(0, 3) != 0);
            end
            if (n == 150) drain_pause();
            if (n == 200) begin
                sink_hold = LONG_HOLD;
                hold_left = 6;
            end
            if (n == RANDOM_ITEMS - 80) calm = 1'b1;
            st       = '0;
            st.axis  = ($urandom_range(0, 15) == 0) ? AXIS_NONE : t_axis'($urandom_range(0, 2));
            st.angle = pick_angle();
            push_item(st);
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                src_gap();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (row_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
